// ===== rtl/sap_pkg.sv =====
// ----------------------------------------------------------------------------
// sap_pkg
// Shared constants, codes and types of the substring position search.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sap_pkg;

   // Capacities
   localparam int MAX_PATTERN = 64;
   localparam int MAX_TEXT    = 256;

   // Derived widths
   localparam int PLEN_W = $clog2(MAX_PATTERN + 1);
   localparam int PIDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int TCNT_W = $clog2(MAX_TEXT + 1);

   // Fixed field widths
   localparam int OPC_W   = 2;
   localparam int BYTE_W  = 8;
   localparam int POS_W   = 8;
   localparam int TOTAL_W = 9;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   // Opcodes
   localparam logic [OPC_W-1:0] OP_START   = 2'd0;
   localparam logic [OPC_W-1:0] OP_PATTERN = 2'd1;
   localparam logic [OPC_W-1:0] OP_TEXT    = 2'd2;

   // Result kinds
   localparam logic KIND_MATCH   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // Result queue
   localparam int RSP_DEPTH   = 8;
   localparam int RSP_PTR_W   = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W   = $clog2(RSP_DEPTH + 1);
   localparam int STALL_LEVEL = RSP_DEPTH - 4;

   // One result item
   typedef struct packed {
      logic               kind;
      logic [POS_W-1:0]   position;
      logic [TOTAL_W-1:0] match_total;
      logic               none_found;
      logic               overflow;
      logic               last;
   } rsp_type;

   // Up to two results produced by one input item
   typedef struct packed {
      logic    push0;
      logic    push1;
      rsp_type res0;
      rsp_type res1;
   } push_type;

endpackage

`default_nettype wire

// ===== rtl/sap_match.sv =====
// ----------------------------------------------------------------------------
// sap_match
// Search state and per-byte match logic. Keeps the pattern bytes and a
// vector of partial-match flags (bit k: pattern bytes 0..k end at the
// newest text byte), updated in one step per text byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sap_match
   import sap_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire logic [OPC_W-1:0]  in_opcode,
   input  wire logic [BYTE_W-1:0] in_data_byte,
   input  wire logic              in_end_of_text,
   output push_type               push
);

   logic [BYTE_W-1:0]      pat_ff [MAX_PATTERN];
   logic [PLEN_W-1:0]      plen_ff, plen_in;
   logic [TCNT_W-1:0]      tcount_ff, tcount_in;
   logic [TOTAL_W-1:0]     mcount_ff, mcount_in;
   logic                   ovf_ff, ovf_in;
   logic                   pover_ff, pover_in;
   logic                   done_ff, done_in;
   logic [MAX_PATTERN-1:0] hits_ff, hits_in;

   logic                   do_start, do_pat, do_text, text_room, pat_room, pat_wr;
   logic [MAX_PATTERN-1:0] eq, hits_next;
   logic [PIDX_W-1:0]      tail_idx;
   logic                   is_match;
   logic [TCNT_W+POS_W-1:0] pos_full;
   rsp_type                match_res, sum_res;

   // Item decode
   assign do_start  = in_valid && (in_opcode == OP_START);
   assign do_pat    = in_valid && !done_ff && (in_opcode == OP_PATTERN)
                      && (tcount_ff == '0);
   assign do_text   = in_valid && !done_ff && (in_opcode == OP_TEXT);
   assign text_room = tcount_ff < TCNT_W'(MAX_TEXT);
   assign pat_room  = plen_ff < PLEN_W'(MAX_PATTERN);
   assign pat_wr    = do_pat && pat_room;

   // Byte compare against every pattern position, shift-and update
   always_comb begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
         eq[k] = (pat_ff[k] == in_data_byte);
      end
      hits_next = {hits_ff[MAX_PATTERN-2:0], 1'b1} & eq;
   end

   assign tail_idx = PIDX_W'(plen_ff - PLEN_W'(1));
   assign is_match = do_text && text_room && (plen_ff != '0) && !pover_ff
                     && hits_next[tail_idx];
   assign pos_full = (TCNT_W+POS_W)'(tcount_ff) + (TCNT_W+POS_W)'(1)
                     - (TCNT_W+POS_W)'(plen_ff);

   // Next state
   always_comb begin
      plen_in   = plen_ff;
      tcount_in = tcount_ff;
      mcount_in = mcount_ff;
      ovf_in    = ovf_ff;
      pover_in  = pover_ff;
      done_in   = done_ff;
      hits_in   = hits_ff;
      if (do_start) begin
         plen_in   = '0;
         tcount_in = '0;
         mcount_in = '0;
         ovf_in    = 1'b0;
         pover_in  = 1'b0;
         done_in   = 1'b0;
         hits_in   = '0;
      end else if (do_pat) begin
         if (pat_room) begin
            plen_in = plen_ff + PLEN_W'(1);
         end else begin
            ovf_in   = 1'b1;
            pover_in = 1'b1;
         end
      end else if (do_text) begin
         if (text_room) begin
            tcount_in = tcount_ff + TCNT_W'(1);
            hits_in   = hits_next;
            if (is_match && (mcount_ff != TOTAL_MAX)) begin
               mcount_in = mcount_ff + TOTAL_W'(1);
            end
         end else begin
            ovf_in = 1'b1;
         end
         if (in_end_of_text) begin
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff   <= '0;
         tcount_ff <= '0;
         mcount_ff <= '0;
         ovf_ff    <= 1'b0;
         pover_ff  <= 1'b0;
         done_ff   <= 1'b0;
         hits_ff   <= '0;
      end else begin
         plen_ff   <= plen_in;
         tcount_ff <= tcount_in;
         mcount_ff <= mcount_in;
         ovf_ff    <= ovf_in;
         pover_ff  <= pover_in;
         done_ff   <= done_in;
         hits_ff   <= hits_in;
      end
   end

   // Pattern bytes, one register per position
   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
         if (pat_wr && (plen_ff[PIDX_W-1:0] == PIDX_W'(k))) begin
            pat_ff[k] <= in_data_byte;
         end
      end
   end

   // Result items
   always_comb begin
      match_res.kind        = KIND_MATCH;
      match_res.position    = pos_full[POS_W-1:0];
      match_res.match_total = mcount_in;
      match_res.none_found  = 1'b0;
      match_res.overflow    = ovf_ff;
      match_res.last        = 1'b0;

      sum_res.kind        = KIND_SUMMARY;
      sum_res.position    = '0;
      sum_res.match_total = mcount_in;
      sum_res.none_found  = (mcount_in == '0);
      sum_res.overflow    = ovf_in;
      sum_res.last        = 1'b1;

      push.push0 = is_match || (do_text && in_end_of_text);
      push.push1 = is_match && in_end_of_text;
      push.res0  = is_match ? match_res : sum_res;
      push.res1  = sum_res;
   end

endmodule

`default_nettype wire

// ===== rtl/sap_fifo.sv =====
// ----------------------------------------------------------------------------
// sap_fifo
// Result queue: takes up to two items per cycle, gives one per cycle when popped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sap_fifo
   import sap_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  push_type            push,
   input  wire logic           pop,
   output rsp_type             head,
   output logic                not_empty,
   output logic [RSP_CNT_W-1:0] count
);

   rsp_type                mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in, wr_next;
   logic [RSP_CNT_W-1:0]   count_ff, count_in;
   logic [1:0]             n_push;

   assign n_push  = {1'b0, push.push0} + {1'b0, push.push1};
   assign wr_next = wr_ff + RSP_PTR_W'(1);

   // Pointer and fill count update
   always_comb begin
      wr_in    = wr_ff + RSP_PTR_W'(n_push);
      rd_in    = pop ? rd_ff + RSP_PTR_W'(1) : rd_ff;
      count_in = count_ff + RSP_CNT_W'(n_push) - (pop ? RSP_CNT_W'(1) : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Entry writes
   always_ff @(posedge clock) begin
      if (push.push0) begin
         mem_ff[wr_ff] <= push.res0;
      end
      if (push.push1) begin
         mem_ff[wr_next] <= push.res1;
      end
   end

   assign head      = mem_ff[rd_ff];
   assign not_empty = (count_ff != '0);
   assign count     = count_ff;

endmodule

`default_nettype wire

// ===== rtl/substring_all_positions.sv =====
// ----------------------------------------------------------------------------
// substring_all_positions
// Reports every start offset of a pattern in a byte stream, overlaps
// included, and a summary at the end of the text.
// ----------------------------------------------------------------------------
// Usage:
//   req_* channel: one item per accepted cycle (req_valid high, req_stall
//   low). A start item clears the search, pattern items append pattern
//   bytes (up to 64), text items stream the text (up to 256 bytes).
//   rsp_* channel: one result item per accepted cycle. A match item carries
//   the start offset; the text byte flagged end_of_text adds a summary item
//   with last set, after its own match item if it has one.
//   A result passes the input register and the result queue before it
//   shows on rsp_*. Throughput: one item per cycle while req_stall is low;
//   each text byte is compared against all pattern positions at once in a
//   single registered step. A stalled receiver fills an eight-entry result
//   queue; req_stall rises once more than four entries are held, so nothing
//   is lost, and a stalled rsp_* item holds steady.
//   Reset (synchronous) leaves the block as after a start item, with the
//   queue empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module substring_all_positions
   import sap_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [OPC_W-1:0]   req_opcode,
   input  wire logic [BYTE_W-1:0]  req_data_byte,
   input  wire logic               req_end_of_text,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_kind,
   output logic [POS_W-1:0]        rsp_position,
   output logic [TOTAL_W-1:0]      rsp_match_total,
   output logic                    rsp_none_found,
   output logic                    rsp_overflow,
   output logic                    rsp_last
);

   logic               stage_valid_ff;
   logic [OPC_W-1:0]   stage_opcode_ff;
   logic [BYTE_W-1:0]  stage_byte_ff;
   logic               stage_eot_ff;
   logic               req_take;
   push_type           push;
   rsp_type            head;
   logic               rsp_pop;
   logic [RSP_CNT_W-1:0] fill;

   // Input register
   assign req_stall = fill > RSP_CNT_W'(STALL_LEVEL);
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= req_take;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_opcode_ff <= req_opcode;
         stage_byte_ff   <= req_data_byte;
         stage_eot_ff    <= req_end_of_text;
      end
   end

   // Search logic
   sap_match u_match (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (stage_valid_ff),
      .in_opcode      (stage_opcode_ff),
      .in_data_byte   (stage_byte_ff),
      .in_end_of_text (stage_eot_ff),
      .push           (push)
   );

   // Result queue
   assign rsp_pop = rsp_valid && !rsp_stall;

   sap_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_pop),
      .head      (head),
      .not_empty (rsp_valid),
      .count     (fill)
   );

   assign rsp_kind        = head.kind;
   assign rsp_position    = head.position;
   assign rsp_match_total = head.match_total;
   assign rsp_none_found  = head.none_found;
   assign rsp_overflow    = head.overflow;
   assign rsp_last        = head.last;

endmodule

`default_nettype wire
